// ===== rtl/mrpt_pkg.sv =====
// Shared constants, command and status types for the primality test core.
`timescale 1ns / 1ps
package mrpt_pkg;

   localparam int WORD_BITS         = 31;
   localparam int SMALL_PRIME_COUNT = 18;
   localparam int WITNESS_COUNT     = 3;
   localparam int BIT_W             = $clog2(WORD_BITS);
   localparam int PRIME_IDX_W       = (SMALL_PRIME_COUNT > 1) ? $clog2(SMALL_PRIME_COUNT) : 1;
   localparam int WIT_IDX_W         = $clog2(WITNESS_COUNT);
   localparam int CSR_IDX_W         = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_WITNESS_FIRST  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WITNESS_SECOND = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WITNESS_THIRD  = 2'd2;

   typedef logic [WORD_BITS-1:0] word_type;

   // Operations of the shared modular multiplier.
   localparam logic [1:0] OP_TRIAL  = 2'd0;
   localparam logic [1:0] OP_REDUCE = 2'd1;
   localparam logic [1:0] OP_SQUARE = 2'd2;
   localparam logic [1:0] OP_MULT   = 2'd3;

   typedef struct packed {
      logic load;
      logic prime_init;
      logic next_prime;
      logic trial_start;
      logic dsplit_init;
      logic d_shift;
      logic wit_init;
      logic next_wit;
      logic reduce_start;
      logic pow_init;
      logic sq_start;
      logic mul_start;
      logic bit_dec;
      logic sq_init;
      logic k_dec;
   } cmd_type;

   typedef struct packed {
      logic n_lt2;
      logic n_even;
      logic n_is2;
      logic n_eq_prime;
      logic last_prime;
      logic eng_done;
      logic res_zero;
      logic res_one;
      logic d_odd;
      logic a_skip;
      logic last_wit;
      logic acc_one;
      logic d_bit;
      logic bit_zero;
      logic sq_bad;
      logic k_last;
   } status_type;

   function automatic word_type small_prime(input logic [PRIME_IDX_W-1:0] idx);
      word_type p;
      case (idx)
         5'd0:    p = word_type'(2);
         5'd1:    p = word_type'(3);
         5'd2:    p = word_type'(5);
         5'd3:    p = word_type'(7);
         5'd4:    p = word_type'(11);
         5'd5:    p = word_type'(13);
         5'd6:    p = word_type'(17);
         5'd7:    p = word_type'(19);
         5'd8:    p = word_type'(23);
         5'd9:    p = word_type'(29);
         5'd10:   p = word_type'(31);
         5'd11:   p = word_type'(37);
         5'd12:   p = word_type'(41);
         5'd13:   p = word_type'(43);
         5'd14:   p = word_type'(47);
         5'd15:   p = word_type'(53);
         5'd16:   p = word_type'(59);
         5'd17:   p = word_type'(61);
         default: p = word_type'(61);
      endcase
      return p;
   endfunction

endpackage

// ===== rtl/mrpt_if.sv =====
// Valid/ready channel interfaces for the request and response beats.
`timescale 1ns / 1ps
interface mrpt_req_if;
   import mrpt_pkg::*;
   logic     valid;
   logic     ready;
   word_type candidate;
   modport source (output valid, output candidate, input ready);
   modport sink (input valid, input candidate, output ready);
endinterface

interface mrpt_rsp_if;
   logic valid;
   logic ready;
   logic prime_flag;
   modport source (output valid, output prime_flag, input ready);
   modport sink (input valid, input prime_flag, output ready);
endinterface

// ===== rtl/mrpt_mulmod.sv =====
// Bit-serial modular multiplier: res = x * b mod m, one bit of b per cycle.
`timescale 1ns / 1ps
module mrpt_mulmod (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  mrpt_pkg::word_type x,
   input  mrpt_pkg::word_type b,
   input  mrpt_pkg::word_type m,
   output logic               done,
   output mrpt_pkg::word_type res
);
   import mrpt_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [BIT_W-1:0]     cnt_ff, cnt_in;
   word_type             acc_ff, acc_in;
   word_type             b_ff, b_in;
   word_type             x_ff, x_in;
   word_type             m_ff, m_in;
   logic [WORD_BITS:0]   dbl, dbl_r, sum, sum_r;

   // Horner step: acc = 2*acc + bit*x, reduced after each add. Requires x < m.
   always_comb begin
      dbl   = {acc_ff, 1'b0};
      dbl_r = (dbl >= {1'b0, m_ff}) ? dbl - {1'b0, m_ff} : dbl;
      sum   = dbl_r + (b_ff[WORD_BITS-1] ? {1'b0, x_ff} : '0);
      sum_r = (sum >= {1'b0, m_ff}) ? sum - {1'b0, m_ff} : sum;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      b_in    = b_ff;
      x_in    = x_ff;
      m_in    = m_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = BIT_W'(WORD_BITS - 1);
         acc_in  = '0;
         b_in    = b;
         x_in    = x;
         m_in    = m;
      end else if (busy_ff) begin
         acc_in = sum_r[WORD_BITS-1:0];
         b_in   = {b_ff[WORD_BITS-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      b_ff   <= b_in;
      x_ff   <= x_in;
      m_ff   <= m_in;
   end

   assign done = done_ff;
   assign res  = acc_ff;
endmodule

// ===== rtl/mrpt_datapath.sv =====
// Datapath: operand registers, witness registers and the shared multiplier.
`timescale 1ns / 1ps
module mrpt_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  mrpt_pkg::cmd_type             cmd,
   output mrpt_pkg::status_type          status,
   input  mrpt_pkg::word_type            candidate,
   input  logic                          csr_wr_en,
   input  logic [mrpt_pkg::CSR_IDX_W-1:0] csr_index,
   input  mrpt_pkg::word_type            csr_wdata
);
   import mrpt_pkg::*;

   word_type               n_ff, n_in;
   word_type               d_ff, d_in;
   logic [BIT_W-1:0]       s_ff, s_in;
   logic [BIT_W-1:0]       k_ff, k_in;
   logic [BIT_W-1:0]       bit_ff, bit_in;
   word_type               acc_ff, acc_in;
   word_type               a_ff, a_in;
   logic [PRIME_IDX_W-1:0] pi_ff, pi_in;
   logic [WIT_IDX_W-1:0]   wi_ff, wi_in;
   logic [1:0]             op_ff, op_in;
   word_type               wit_ff [WITNESS_COUNT];

   logic     eng_start, eng_done;
   word_type eng_x, eng_b, eng_m, eng_res, cur_prime, nm1;

   assign cur_prime = small_prime(pi_ff);
   assign nm1       = n_ff - 1'b1;

   always_comb begin
      eng_start = cmd.trial_start | cmd.reduce_start | cmd.sq_start | cmd.mul_start;
      eng_x     = acc_ff;
      eng_b     = acc_ff;
      eng_m     = n_ff;
      if (cmd.trial_start) begin
         eng_x = word_type'(1);
         eng_b = n_ff;
         eng_m = cur_prime;
      end else if (cmd.reduce_start) begin
         eng_x = word_type'(1);
         eng_b = wit_ff[wi_ff];
      end else if (cmd.mul_start) begin
         eng_b = a_ff;
      end
   end

   mrpt_mulmod u_mulmod (
      .clock (clock),
      .reset (reset),
      .start (eng_start),
      .x     (eng_x),
      .b     (eng_b),
      .m     (eng_m),
      .done  (eng_done),
      .res   (eng_res)
   );

   always_comb begin
      n_in   = n_ff;
      d_in   = d_ff;
      s_in   = s_ff;
      k_in   = k_ff;
      bit_in = bit_ff;
      acc_in = acc_ff;
      a_in   = a_ff;
      pi_in  = pi_ff;
      wi_in  = wi_ff;
      op_in  = op_ff;
      if (cmd.load)        n_in = candidate;
      if (cmd.prime_init)  pi_in = '0;
      if (cmd.next_prime)  pi_in = pi_ff + 1'b1;
      if (cmd.dsplit_init) begin
         d_in = nm1;
         s_in = '0;
      end
      if (cmd.d_shift) begin
         d_in = {1'b0, d_ff[WORD_BITS-1:1]};
         s_in = s_ff + 1'b1;
      end
      if (cmd.wit_init)    wi_in = '0;
      if (cmd.next_wit)    wi_in = wi_ff + 1'b1;
      if (cmd.pow_init) begin
         acc_in = word_type'(1);
         bit_in = BIT_W'(WORD_BITS - 1);
      end
      if (cmd.bit_dec)     bit_in = bit_ff - 1'b1;
      if (cmd.sq_init)     k_in = s_ff;
      if (cmd.k_dec)       k_in = k_ff - 1'b1;
      if (cmd.trial_start)  op_in = OP_TRIAL;
      if (cmd.reduce_start) op_in = OP_REDUCE;
      if (cmd.sq_start)     op_in = OP_SQUARE;
      if (cmd.mul_start)    op_in = OP_MULT;
      if (eng_done) begin
         case (op_ff)
            OP_REDUCE:         a_in = eng_res;
            OP_SQUARE, OP_MULT: acc_in = eng_res;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      d_ff   <= d_in;
      s_ff   <= s_in;
      k_ff   <= k_in;
      bit_ff <= bit_in;
      acc_ff <= acc_in;
      a_ff   <= a_in;
      pi_ff  <= pi_in;
      wi_ff  <= wi_in;
      op_ff  <= op_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wit_ff[0] <= word_type'(2);
         wit_ff[1] <= word_type'(7);
         wit_ff[2] <= word_type'(61);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_WITNESS_FIRST:  wit_ff[0] <= csr_wdata;
            CSR_WITNESS_SECOND: wit_ff[1] <= csr_wdata;
            CSR_WITNESS_THIRD:  wit_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      status.n_lt2      = (n_ff < word_type'(2));
      status.n_even     = ~n_ff[0];
      status.n_is2      = (n_ff == word_type'(2));
      status.n_eq_prime = (n_ff == cur_prime);
      status.last_prime = (pi_ff == PRIME_IDX_W'(SMALL_PRIME_COUNT - 1));
      status.eng_done   = eng_done;
      status.res_zero   = (eng_res == '0);
      status.res_one    = (eng_res == word_type'(1));
      status.d_odd      = d_ff[0];
      status.a_skip     = (a_ff == '0) || (a_ff == word_type'(1)) || (a_ff == nm1);
      status.last_wit   = (wi_ff == WIT_IDX_W'(WITNESS_COUNT - 1));
      status.acc_one    = (acc_ff == word_type'(1));
      status.d_bit      = d_ff[bit_ff];
      status.bit_zero   = (bit_ff == '0);
      // A square that lands on 1 from anything but +1 or -1 proves n composite.
      status.sq_bad     = (eng_res == word_type'(1)) && (acc_ff != word_type'(1))
                          && (acc_ff != nm1);
      status.k_last     = (k_ff == BIT_W'(1));
   end
endmodule

// ===== rtl/mrpt_ctrl.sv =====
// Controller state machine: sequences screening, trial division and the rounds.
`timescale 1ns / 1ps
module mrpt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_flag,
   output mrpt_pkg::cmd_type    cmd,
   input  mrpt_pkg::status_type status
);
   import mrpt_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_CHECK  = 4'd1;
   localparam logic [3:0] S_TRIAL  = 4'd2;
   localparam logic [3:0] S_TWAIT  = 4'd3;
   localparam logic [3:0] S_DSPLIT = 4'd4;
   localparam logic [3:0] S_WRED   = 4'd5;
   localparam logic [3:0] S_WWAIT  = 4'd6;
   localparam logic [3:0] S_WCHK   = 4'd7;
   localparam logic [3:0] S_PSQ    = 4'd8;
   localparam logic [3:0] S_PSQW   = 4'd9;
   localparam logic [3:0] S_PMUL   = 4'd10;
   localparam logic [3:0] S_PMULW  = 4'd11;
   localparam logic [3:0] S_SQ     = 4'd12;
   localparam logic [3:0] S_SQW    = 4'd13;
   localparam logic [3:0] S_DONE   = 4'd14;

   logic [3:0] state_ff, state_in;
   logic       verdict_ff, verdict_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_flag_ff, rsp_flag_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      verdict_in   = verdict_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_flag_in  = rsp_flag_ff;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (status.n_lt2) begin
               verdict_in = 1'b0;
               state_in   = S_DONE;
            end else if (status.n_even) begin
               verdict_in = status.n_is2;
               state_in   = S_DONE;
            end else begin
               cmd.prime_init = 1'b1;
               state_in       = S_TRIAL;
            end
         end
         S_TRIAL: begin
            if (status.n_eq_prime) begin
               verdict_in = 1'b1;
               state_in   = S_DONE;
            end else begin
               cmd.trial_start = 1'b1;
               state_in        = S_TWAIT;
            end
         end
         S_TWAIT: begin
            if (status.eng_done) begin
               if (status.res_zero) begin
                  verdict_in = 1'b0;
                  state_in   = S_DONE;
               end else if (status.last_prime) begin
                  cmd.dsplit_init = 1'b1;
                  state_in        = S_DSPLIT;
               end else begin
                  cmd.next_prime = 1'b1;
                  state_in       = S_TRIAL;
               end
            end
         end
         S_DSPLIT: begin
            if (status.d_odd) begin
               cmd.wit_init = 1'b1;
               state_in     = S_WRED;
            end else begin
               cmd.d_shift = 1'b1;
            end
         end
         S_WRED: begin
            cmd.reduce_start = 1'b1;
            state_in         = S_WWAIT;
         end
         S_WWAIT: begin
            if (status.eng_done) state_in = S_WCHK;
         end
         S_WCHK: begin
            if (!status.a_skip) begin
               cmd.pow_init = 1'b1;
               state_in     = S_PSQ;
            end else if (status.last_wit) begin
               verdict_in = 1'b1;
               state_in   = S_DONE;
            end else begin
               cmd.next_wit = 1'b1;
               state_in     = S_WRED;
            end
         end
         S_PSQ: begin
            // Squaring 1 gives 1, so leading exponent zeros cost no multiplier pass.
            if (status.acc_one) begin
               state_in = S_PMUL;
            end else begin
               cmd.sq_start = 1'b1;
               state_in     = S_PSQW;
            end
         end
         S_PSQW: begin
            if (status.eng_done) state_in = S_PMUL;
         end
         S_PMUL: begin
            if (status.d_bit) begin
               cmd.mul_start = 1'b1;
               state_in      = S_PMULW;
            end else if (status.bit_zero) begin
               cmd.sq_init = 1'b1;
               state_in    = S_SQ;
            end else begin
               cmd.bit_dec = 1'b1;
               state_in    = S_PSQ;
            end
         end
         S_PMULW: begin
            if (status.eng_done) begin
               if (status.bit_zero) begin
                  cmd.sq_init = 1'b1;
                  state_in    = S_SQ;
               end else begin
                  cmd.bit_dec = 1'b1;
                  state_in    = S_PSQ;
               end
            end
         end
         S_SQ: begin
            cmd.sq_start = 1'b1;
            state_in     = S_SQW;
         end
         S_SQW: begin
            if (status.eng_done) begin
               if (status.sq_bad) begin
                  verdict_in = 1'b0;
                  state_in   = S_DONE;
               end else if (!status.k_last) begin
                  cmd.k_dec = 1'b1;
                  state_in  = S_SQ;
               end else if (!status.res_one) begin
                  verdict_in = 1'b0;
                  state_in   = S_DONE;
               end else if (status.last_wit) begin
                  verdict_in = 1'b1;
                  state_in   = S_DONE;
               end else begin
                  cmd.next_wit = 1'b1;
                  state_in     = S_WRED;
               end
            end
         end
         S_DONE: begin
            // Wait here only while the previous response beat is still held.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_flag_in  = verdict_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      verdict_ff  <= verdict_in;
      rsp_flag_ff <= rsp_flag_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_flag  = rsp_flag_ff;
endmodule

// ===== rtl/miller_rabin_primality_test_core.sv =====
// Top level of the Miller-Rabin primality test core.
//
//   Channel   Direction  Handshake          Payload
//   req_bus   in         valid/ready        candidate (31 bits)
//   rsp_bus   out        valid/ready        prime_flag (1 bit)
//   csr_*     in         csr_wr_en only     csr_index (2 bits), csr_wdata (31 bits)
//
// One candidate is processed at a time. Values below 2 and even values are decided at the
// screening check; trial division and each Miller-Rabin round run their modular products
// one after another on the shared bit-serial multiplier.
// Reset is synchronous and restores the witnesses 2, 7 and 61. The request side is ready
// again once the verdict has moved into the response register; while an earlier response
// beat is still held, the core waits in its done state and is not ready.
`timescale 1ns / 1ps
module miller_rabin_primality_test_core (
   input  logic                           clock,
   input  logic                           reset,
   mrpt_req_if.sink                       req_bus,
   mrpt_rsp_if.source                     rsp_bus,
   input  logic                           csr_wr_en,
   input  logic [mrpt_pkg::CSR_IDX_W-1:0] csr_index,
   input  mrpt_pkg::word_type             csr_wdata
);
   import mrpt_pkg::*;

   cmd_type    cmd;
   status_type status;

   mrpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .rsp_flag  (rsp_bus.prime_flag),
      .cmd       (cmd),
      .status    (status)
   );

   mrpt_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .candidate (req_bus.candidate),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );
endmodule
